// File: rtl/idll_pkg.sv
// Shared types and constants for the indexed doubly linked list.
package idll_pkg;

  localparam int POOL_SLOTS_DEF = 1024;
  localparam int OP_W           = 3;
  localparam int IDX_W          = 10;
  localparam int VAL_W          = 32;

  // command queue between front and back (power of two)
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_DELETE     = 3'd2,
    OP_INS_LEFT   = 3'd3,
    OP_INS_RIGHT  = 3'd4,
    OP_READ       = 3'd5,
    OP_NOP        = 3'd6
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    logic     insert;
  } ctl_t;

  typedef enum logic {
    PH_ISSUE,
    PH_FINISH
  } ph_t;

endpackage

// File: rtl/indexed_doubly_linked_list.sv
// Top level of the indexed doubly linked list: front end, command queue and executor.
//
// Usage:
//   Commands enter on start/busy: a beat is taken at a clock edge with start high
//   and busy low. in_operation picks push front/back, delete, insert left/right
//   of in_node_index, or read of in_node_index; in_item_value is the new node's
//   value. Nodes take slots 1, 2, 3... in insertion order; slot 0 is null.
//   Each command yields exactly one result beat, marked by out_valid for one
//   cycle. The receiver cannot hold it off, so results are never backed up.
//   A command passes from the queue through the issue and finish phases of the
//   executor to the output register. The executor finishes each command before
//   it takes another: one phase reads a node's links, the next writes the
//   neighbor links, and each link memory has one write port. A 2-deep command
//   queue absorbs back-to-back starts; busy is high while it is full.
//   A full pool refuses inserts with out_op_status high and out_new_slot 0.
//   Reset (rst_n low, synchronous) empties the list and queue; node memories
//   are not cleared; the user must read a slot only after it is written (not enforced).
module indexed_doubly_linked_list import idll_pkg::*; #(
  parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [OP_W-1:0]         in_operation,
  input  logic [IDX_W-1:0]        in_node_index,
  input  logic signed [VAL_W-1:0] in_item_value,
  output logic                    out_valid,
  output logic                    out_op_status,
  output logic [IDX_W-1:0]        out_new_slot,
  output logic [IDX_W-1:0]        out_head_slot,
  output logic [IDX_W-1:0]        out_tail_slot,
  output logic signed [VAL_W-1:0] out_read_value,
  output logic [IDX_W-1:0]        out_read_prev,
  output logic [IDX_W-1:0]        out_read_next
);

  localparam int SLOT_W = $clog2(POOL_SLOTS);

  // queue head toward the executor
  logic              q_valid;
  ctl_t              q_ctl;
  logic [SLOT_W-1:0] q_slot;
  logic [VAL_W-1:0]  q_value;
  logic              q_pop;

  idll_front #(.POOL_SLOTS(POOL_SLOTS), .SLOT_W(SLOT_W)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_node_index (in_node_index),
    .in_item_value (in_item_value),
    .q_valid       (q_valid),
    .q_ctl         (q_ctl),
    .q_slot        (q_slot),
    .q_value       (q_value),
    .q_pop         (q_pop)
  );

  idll_back #(.POOL_SLOTS(POOL_SLOTS), .SLOT_W(SLOT_W)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_ctl          (q_ctl),
    .q_slot         (q_slot),
    .q_value        (q_value),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_op_status  (out_op_status),
    .out_new_slot   (out_new_slot),
    .out_head_slot  (out_head_slot),
    .out_tail_slot  (out_tail_slot),
    .out_read_value (out_read_value),
    .out_read_prev  (out_read_prev),
    .out_read_next  (out_read_next)
  );

  // the executor returns to its issue phase after each finish phase, so result beats never abut
  a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beats in consecutive cycles");

  // a refused insert never hands out a slot
  a_refused_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_op_status |-> out_new_slot == '0)
    else $error("refused insert reported a slot");

  // a command is popped only when the queue holds one
  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("executor popped an empty queue");

endmodule

// File: rtl/idll_ram.sv
// Generic single-port-write, single-port-read RAM with registered read-first output.
module idll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/idll_front.sv
// Front end: accepts commands, classifies the operation code, and queues them.
module idll_front import idll_pkg::*; #(
  parameter int POOL_SLOTS = POOL_SLOTS_DEF,
  parameter int SLOT_W     = $clog2(POOL_SLOTS)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [OP_W-1:0]         in_operation,
  input  logic [IDX_W-1:0]        in_node_index,
  input  logic signed [VAL_W-1:0] in_item_value,
  output logic                    q_valid,
  output ctl_t                    q_ctl,
  output logic [SLOT_W-1:0]       q_slot,
  output logic [VAL_W-1:0]        q_value,
  input  logic                    q_pop
);

  ctl_t              ctl_q   [QDEPTH];
  logic [SLOT_W-1:0] slot_q  [QDEPTH];
  logic [VAL_W-1:0]  value_q [QDEPTH];

  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  ctl_t              in_ctl;
  logic [SLOT_W-1:0] in_slot;
  logic              push;
  logic              pop;

  // classify: unknown codes become a no-op, out-of-pool index becomes null
  always_comb begin
    if (in_operation inside {[OP_PUSH_FRONT:OP_READ]}) begin
      in_ctl.kind = op_kind_t'(in_operation);
    end else begin
      in_ctl.kind = OP_NOP;
    end
    in_ctl.insert = in_ctl.kind inside {OP_PUSH_FRONT, OP_PUSH_BACK, OP_INS_LEFT, OP_INS_RIGHT};
    if (32'(in_node_index) < POOL_SLOTS) begin
      in_slot = SLOT_W'(in_node_index);
    end else begin
      in_slot = '0;
    end
  end

  assign busy    = (cnt_r == QCNT_W'(QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign pop     = q_pop && q_valid;

  assign q_ctl   = ctl_q[rd_ptr_r];
  assign q_slot  = slot_q[rd_ptr_r];
  assign q_value = value_q[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_q[wr_ptr_r]   <= in_ctl;
      slot_q[wr_ptr_r]  <= in_slot;
      value_q[wr_ptr_r] <= in_item_value;
    end
  end

endmodule

// File: rtl/idll_back.sv
// Back end: two-phase executor over the value and link memories, holds head/tail/count.
module idll_back import idll_pkg::*; #(
  parameter int POOL_SLOTS = POOL_SLOTS_DEF,
  parameter int SLOT_W     = $clog2(POOL_SLOTS)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  ctl_t                    q_ctl,
  input  logic [SLOT_W-1:0]       q_slot,
  input  logic [VAL_W-1:0]        q_value,
  output logic                    q_pop,
  output logic                    out_valid,
  output logic                    out_op_status,
  output logic [IDX_W-1:0]        out_new_slot,
  output logic [IDX_W-1:0]        out_head_slot,
  output logic [IDX_W-1:0]        out_tail_slot,
  output logic signed [VAL_W-1:0] out_read_value,
  output logic [IDX_W-1:0]        out_read_prev,
  output logic [IDX_W-1:0]        out_read_next
);

  ph_t ph_r, ph_nxt;

  logic [SLOT_W-1:0] head_r, head_nxt, tail_r, tail_nxt, used_r, used_nxt;
  logic [SLOT_W-1:0] h1, t1;

  // command latched in the issue phase
  op_kind_t          kind_r;
  logic              full_r, zero_r;
  logic [SLOT_W-1:0] slot_r, fresh_r;

  logic [SLOT_W-1:0] q_fresh;
  logic              q_full;

  logic              val_we;
  logic [VAL_W-1:0]  val_rd;
  logic              prev_req, next_req, prev_we, next_we;
  logic [SLOT_W-1:0] prev_waddr, prev_wdata, next_waddr, next_wdata;
  logic [SLOT_W-1:0] prev_rd, next_rd, lnk_l, lnk_r;

  logic                    out_valid_r, out_status_r;
  logic [IDX_W-1:0]        out_new_r, out_head_r, out_tail_r, out_rp_r, out_rn_r;
  logic signed [VAL_W-1:0] out_rv_r;

  assign q_fresh = used_r + 1'b1;
  assign q_full  = (used_r >= SLOT_W'(POOL_SLOTS - 1));

  // slot 0 is never written and reads as zero
  assign lnk_l = zero_r ? '0 : prev_rd;
  assign lnk_r = zero_r ? '0 : next_rd;

  idll_ram #(.WIDTH(VAL_W), .DEPTH(POOL_SLOTS)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (q_fresh),
    .wdata (q_value),
    .raddr (q_slot),
    .rdata (val_rd)
  );

  idll_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_SLOTS)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (q_slot),
    .rdata (prev_rd)
  );

  idll_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_SLOTS)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (q_slot),
    .rdata (next_rd)
  );

  // next state
  always_comb begin
    ph_nxt = ph_r;
    case (ph_r)
      PH_ISSUE:  if (q_valid) ph_nxt = PH_FINISH;
      PH_FINISH: ph_nxt = PH_ISSUE;
      default:   ph_nxt = PH_ISSUE;
    endcase
  end

  // memory control per phase; issue reads old links read-first while it writes
  always_comb begin
    q_pop      = 1'b0;
    val_we     = 1'b0;
    prev_req   = 1'b0;
    prev_waddr = '0;
    prev_wdata = '0;
    next_req   = 1'b0;
    next_waddr = '0;
    next_wdata = '0;
    case (ph_r)
      PH_ISSUE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_ctl.insert && !q_full) begin
            val_we = 1'b1;
            case (q_ctl.kind)
              OP_PUSH_FRONT: begin
                prev_req = 1'b1; prev_waddr = q_fresh; prev_wdata = '0;
                next_req = 1'b1; next_waddr = q_fresh; next_wdata = head_r;
              end
              OP_PUSH_BACK: begin
                prev_req = 1'b1; prev_waddr = q_fresh; prev_wdata = tail_r;
                next_req = 1'b1; next_waddr = q_fresh; next_wdata = '0;
              end
              OP_INS_LEFT: begin
                prev_req = 1'b1; prev_waddr = q_slot;  prev_wdata = q_fresh;
                next_req = 1'b1; next_waddr = q_fresh; next_wdata = q_slot;
              end
              OP_INS_RIGHT: begin
                prev_req = 1'b1; prev_waddr = q_fresh; prev_wdata = q_slot;
                next_req = 1'b1; next_waddr = q_slot;  next_wdata = q_fresh;
              end
              default: ;
            endcase
          end
        end
      end
      PH_FINISH: begin
        if (!full_r) begin
          case (kind_r)
            OP_PUSH_FRONT: begin
              prev_req = 1'b1; prev_waddr = head_r; prev_wdata = fresh_r;
            end
            OP_PUSH_BACK: begin
              next_req = 1'b1; next_waddr = tail_r; next_wdata = fresh_r;
            end
            OP_DELETE: begin
              prev_req = 1'b1; prev_waddr = lnk_r; prev_wdata = lnk_l;
              next_req = 1'b1; next_waddr = lnk_l; next_wdata = lnk_r;
            end
            OP_INS_LEFT: begin
              prev_req = 1'b1; prev_waddr = fresh_r; prev_wdata = lnk_l;
              next_req = 1'b1; next_waddr = lnk_l;   next_wdata = fresh_r;
            end
            OP_INS_RIGHT: begin
              prev_req = 1'b1; prev_waddr = lnk_r;   prev_wdata = fresh_r;
              next_req = 1'b1; next_waddr = fresh_r; next_wdata = lnk_r;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // writes to the null slot are dropped
  assign prev_we = prev_req && (prev_waddr != '0);
  assign next_we = next_req && (next_waddr != '0);

  // head/tail/count after the finishing phase
  always_comb begin
    h1       = (head_r == '0) ? fresh_r : head_r;
    t1       = (tail_r == '0) ? fresh_r : tail_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    used_nxt = used_r;
    if (ph_r == PH_FINISH && !full_r) begin
      case (kind_r)
        OP_PUSH_FRONT: begin
          head_nxt = fresh_r; tail_nxt = t1; used_nxt = fresh_r;
        end
        OP_PUSH_BACK: begin
          head_nxt = h1; tail_nxt = fresh_r; used_nxt = fresh_r;
        end
        OP_DELETE: begin
          if (head_r == slot_r) head_nxt = lnk_r;
          if (tail_r == slot_r) tail_nxt = lnk_l;
        end
        OP_INS_LEFT: begin
          head_nxt = (h1 == slot_r) ? fresh_r : h1;
          tail_nxt = t1;
          used_nxt = fresh_r;
        end
        OP_INS_RIGHT: begin
          head_nxt = h1;
          tail_nxt = (t1 == slot_r) ? fresh_r : t1;
          used_nxt = fresh_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_ISSUE;
      head_r      <= '0;
      tail_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ph_r        <= ph_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      used_r      <= used_nxt;
      out_valid_r <= (ph_r == PH_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (ph_r == PH_ISSUE && q_valid) begin
      kind_r  <= q_ctl.kind;
      full_r  <= q_ctl.insert && q_full;
      zero_r  <= (q_slot == '0);
      slot_r  <= q_slot;
      fresh_r <= q_fresh;
    end
    if (ph_r == PH_FINISH) begin
      out_status_r <= full_r;
      out_new_r    <= (full_r || !(kind_r inside {OP_PUSH_FRONT, OP_PUSH_BACK,
                       OP_INS_LEFT, OP_INS_RIGHT})) ? '0 : IDX_W'(fresh_r);
      out_head_r   <= IDX_W'(head_nxt);
      out_tail_r   <= IDX_W'(tail_nxt);
      if (kind_r == OP_READ && !zero_r) begin
        out_rv_r <= val_rd;
        out_rp_r <= IDX_W'(lnk_l);
        out_rn_r <= IDX_W'(lnk_r);
      end else begin
        out_rv_r <= '0;
        out_rp_r <= '0;
        out_rn_r <= '0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_op_status  = out_status_r;
  assign out_new_slot   = out_new_r;
  assign out_head_slot  = out_head_r;
  assign out_tail_slot  = out_tail_r;
  assign out_read_value = out_rv_r;
  assign out_read_prev  = out_rp_r;
  assign out_read_next  = out_rn_r;

endmodule

// File: verif/indexed_doubly_linked_list_test.sv
// Self-checking testbench for the indexed doubly linked list: directed and random commands.
module indexed_doubly_linked_list_test import idll_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL        = POOL_SLOTS_DEF;
  localparam int LAST_SLOT   = POOL - 1;     // inserts that can ever succeed
  localparam int RANDOM_CMDS = 1500;
  localparam int MAX_GAP     = 11;
  localparam int DRAIN       = 16;           // wait after the last beat, well past the block's latency
  localparam int CYCLE_LIMIT = 200000;       // about 1.5k beats plus their gaps, with lots of slack
  localparam int PRINT_CAP   = 40;           // keep the log short when the block is badly off

  // Operation code the package leaves unnamed; the block must treat it as a no-op.
  localparam logic [OP_W-1:0] OP_SPARE = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    logic [3:0]       gap;       // idle cycles the sender waits before this beat
  } list_cmd_t;

  typedef struct packed {
    logic             status;
    logic [IDX_W-1:0] new_slot;
    logic [IDX_W-1:0] head;
    logic [IDX_W-1:0] tail;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] left_link;
    logic [IDX_W-1:0] right_link;
  } list_beat_t;

  // ---------------------------------------------------------------------------
  // DUT hookup. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic                    clk           = 1'b0;
  logic                    rst_n         = 1'b0;
  logic                    start         = 1'b0;
  logic [OP_W-1:0]         in_operation  = '0;
  logic [IDX_W-1:0]        in_node_index = '0;
  logic signed [VAL_W-1:0] in_item_value = '0;
  logic                    busy;
  logic                    out_valid;
  logic                    out_op_status;
  logic [IDX_W-1:0]        out_new_slot;
  logic [IDX_W-1:0]        out_head_slot;
  logic [IDX_W-1:0]        out_tail_slot;
  logic signed [VAL_W-1:0] out_read_value;
  logic [IDX_W-1:0]        out_read_prev;
  logic [IDX_W-1:0]        out_read_next;

  indexed_doubly_linked_list i_dut (
    .clk, .rst_n, .start, .busy,
    .in_operation, .in_node_index, .in_item_value,
    .out_valid, .out_op_status, .out_new_slot, .out_head_slot, .out_tail_slot,
    .out_read_value, .out_read_prev, .out_read_next
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Mirror of the list: node pool, end pointers and slot allocation counter.
  // Slot 0 is the null link; writes to it are dropped and it reads as zero.
  // ---------------------------------------------------------------------------
  logic [VAL_W-1:0] mirror_value [POOL];
  logic [IDX_W-1:0] mirror_prev  [POOL];
  logic [IDX_W-1:0] mirror_next  [POOL];
  logic [IDX_W-1:0] mirror_head = '0;
  logic [IDX_W-1:0] mirror_tail = '0;
  int               mirror_used = 0;

  int op_seen [8];
  int refused_inserts = 0;
  int accepted_cmds   = 0;
  int checked_beats   = 0;
  int fail_count      = 0;
  int cycle_count     = 0;

  list_cmd_t  pending_cmds [$];
  list_beat_t expected_beats [$];

  function automatic bit is_insert(logic [OP_W-1:0] op);
    return op == OP_PUSH_FRONT || op == OP_PUSH_BACK || op == OP_INS_LEFT || op == OP_INS_RIGHT;
  endfunction

  function automatic logic [IDX_W-1:0] prev_of(logic [IDX_W-1:0] s);
    return (s != 0) ? mirror_prev[s] : '0;
  endfunction

  function automatic logic [IDX_W-1:0] next_of(logic [IDX_W-1:0] s);
    return (s != 0) ? mirror_next[s] : '0;
  endfunction

  function automatic void link_prev(logic [IDX_W-1:0] s, logic [IDX_W-1:0] v);
    if (s != 0) mirror_prev[s] = v;
  endfunction

  function automatic void link_next(logic [IDX_W-1:0] s, logic [IDX_W-1:0] v);
    if (s != 0) mirror_next[s] = v;
  endfunction

  // Next slot in insertion order; an empty end pointer grabs the new node.
  function automatic logic [IDX_W-1:0] make_node(logic [VAL_W-1:0] v, logic [IDX_W-1:0] l,
                                                 logic [IDX_W-1:0] r);
    logic [IDX_W-1:0] s;
    mirror_used++;
    s = IDX_W'(mirror_used);
    mirror_value[s] = v;
    mirror_prev[s]  = l;
    mirror_next[s]  = r;
    if (mirror_head == 0) mirror_head = s;
    if (mirror_tail == 0) mirror_tail = s;
    return s;
  endfunction

  // Applies one command to the mirror and returns the beat the block owes for it.
  function automatic list_beat_t predict_list_op(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                                 logic [VAL_W-1:0] val);
    list_beat_t       b;
    logic [IDX_W-1:0] fresh;
    logic [IDX_W-1:0] l;
    logic [IDX_W-1:0] r;
    b     = '0;
    fresh = '0;
    op_seen[op]++;
    if (is_insert(op) && mirror_used >= LAST_SLOT) begin
      // pool full: nothing changes, refusal flagged
      b.status = 1'b1;
      refused_inserts++;
    end else begin
      case (op)
        OP_PUSH_FRONT: begin
          fresh = make_node(val, '0, mirror_head);
          if (mirror_head != fresh) link_prev(mirror_head, fresh);
          mirror_head = fresh;
        end
        OP_PUSH_BACK: begin
          fresh = make_node(val, mirror_tail, '0);
          if (mirror_tail != fresh) link_next(mirror_tail, fresh);
          mirror_tail = fresh;
        end
        OP_INS_LEFT: begin
          l     = prev_of(idx);
          fresh = make_node(val, l, idx);
          link_next(l, fresh);
          link_prev(idx, fresh);
          if (mirror_head == idx) mirror_head = fresh;
        end
        OP_INS_RIGHT: begin
          r     = next_of(idx);
          fresh = make_node(val, idx, r);
          link_prev(r, fresh);
          link_next(idx, fresh);
          if (mirror_tail == idx) mirror_tail = fresh;
        end
        OP_DELETE: begin
          // both links are read before any neighbor is touched
          l = prev_of(idx);
          r = next_of(idx);
          link_next(l, r);
          link_prev(r, l);
          if (mirror_head == idx) mirror_head = r;
          if (mirror_tail == idx) mirror_tail = l;
        end
        OP_READ: begin
          if (idx != 0) begin
            b.value      = mirror_value[idx];
            b.left_link  = mirror_prev[idx];
            b.right_link = mirror_next[idx];
          end
        end
        default: ;   // spare codes: report head/tail only
      endcase
    end
    b.new_slot = fresh;
    b.head     = mirror_head;
    b.tail     = mirror_tail;
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus planning. The planner keeps its own count of handed-out slots so
  // that no command ever names a slot that has not been written yet, and a
  // rough set of live nodes so most commands hit real list members.
  // ---------------------------------------------------------------------------
  int               plan_used = 0;
  logic [IDX_W-1:0] plan_live [$];
  bit               no_gap    = 1'b0;

  function automatic logic [IDX_W-1:0] pick_target();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85 && plan_live.size() != 0) return plan_live[$urandom_range(0, plan_live.size() - 1)];
    if (r < 97 && plan_used != 0) return IDX_W'($urandom_range(1, plan_used));
    return '0;   // null slot
  endfunction

  task automatic queue_cmd(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
    list_cmd_t c;
    // every 64 beats, maybe switch to a back-to-back stretch
    if (pending_cmds.size() % 64 == 0) no_gap = ($urandom_range(0, 3) == 0);
    c.op  = op;
    c.idx = idx;
    c.val = val;
    c.gap = no_gap ? 4'd0 : 4'($urandom_range(0, MAX_GAP));
    if (is_insert(op) && plan_used < LAST_SLOT) begin
      plan_used++;
      plan_live.push_back(IDX_W'(plan_used));
    end
    if (op == OP_DELETE) begin
      for (int k = 0; k < plan_live.size(); k++) begin
        if (plan_live[k] == idx) begin
          plan_live.delete(k);
          break;
        end
      end
    end
    pending_cmds.push_back(c);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: start/busy sender. A beat goes over at an edge with start high and
  // busy low; that same edge feeds the mirror with the values on the ports.
  // While busy holds a beat off, start and payload stay put.
  // ---------------------------------------------------------------------------
  list_cmd_t staged_cmd;
  bit        staged   = 1'b0;
  int        gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_beats.push_back(predict_list_op(in_operation, in_node_index, in_item_value));
        accepted_cmds++;
      end
      if (!(start && busy)) begin
        if (!staged && pending_cmds.size() != 0) begin
          staged_cmd = pending_cmds.pop_front();
          staged     = 1'b1;
          gap_left   = staged_cmd.gap;
        end
        if (staged && gap_left == 0) begin
          start         <= 1'b1;
          in_operation  <= staged_cmd.op;
          in_node_index <= staged_cmd.idx;
          in_item_value <= staged_cmd.val;
          staged = 1'b0;
        end else begin
          if (gap_left != 0) gap_left--;
          // idle: scribble on the payload, the block must ignore it
          start         <= 1'b0;
          in_operation  <= OP_W'($urandom);
          in_node_index <= IDX_W'($urandom);
          in_item_value <= $urandom;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: out_valid marks a one-cycle result beat; there is no back-pressure.
  // ---------------------------------------------------------------------------
  list_beat_t want_beat;

  task automatic report_mismatch(string what);
    fail_count++;
    if (fail_count <= PRINT_CAP) $display("[%0d] mismatch: %s", cycle_count, what);
  endtask

  task automatic check_field(string name, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("beat %0d %s got %0h want %0h", checked_beats, name, got, want));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("result beat with no command outstanding");
      end else begin
        want_beat = expected_beats.pop_front();
        check_field("op_status",  32'(out_op_status),  32'(want_beat.status));
        check_field("new_slot",   32'(out_new_slot),   32'(want_beat.new_slot));
        check_field("head_slot",  32'(out_head_slot),  32'(want_beat.head));
        check_field("tail_slot",  32'(out_tail_slot),  32'(want_beat.tail));
        check_field("read_value", out_read_value,      want_beat.value);
        check_field("read_prev",  32'(out_read_prev),  32'(want_beat.left_link));
        check_field("read_next",  32'(out_read_next),  32'(want_beat.right_link));
        checked_beats++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: plan everything up front, release reset, wait for the drain.
  // ---------------------------------------------------------------------------
  initial begin
    int               r;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    for (int s = 0; s < POOL; s++) begin
      mirror_value[s] = '0;
      mirror_prev[s]  = '0;
      mirror_next[s]  = '0;
    end
    for (int k = 0; k < 8; k++) op_seen[k] = 0;

    // Directed: empty list, spare codes, inserts at both ends and in the
    // middle, deletes of head/tail/middle, a dead node, and the null slot.
    queue_cmd(OP_READ,       10'd0,    32'h0);          // read of null on empty list
    queue_cmd(OP_DELETE,     10'd0,    32'h0);          // delete of null on empty list
    queue_cmd(OP_NOP,        10'd0,    32'hFFFF_FFFF);
    queue_cmd(OP_SPARE,      10'h3FF,  32'h8000_0000);
    queue_cmd(OP_PUSH_FRONT, 10'h3FF,  32'h7FFF_FFFF);  // slot 1, both ends empty
    queue_cmd(OP_PUSH_BACK,  10'd0,    32'h8000_0000);  // slot 2
    queue_cmd(OP_INS_LEFT,   10'd1,    32'hFFFF_FFFF);  // slot 3, new head
    queue_cmd(OP_INS_RIGHT,  10'd2,    32'h0);          // slot 4, new tail
    queue_cmd(OP_INS_LEFT,   10'd2,    32'h5555_5555);  // slot 5, middle
    queue_cmd(OP_INS_RIGHT,  10'd1,    32'hAAAA_AAAA);  // slot 6, middle
    queue_cmd(OP_READ,       10'd3,    32'h0);
    queue_cmd(OP_READ,       10'd4,    32'h0);
    queue_cmd(OP_READ,       10'd5,    32'h0);
    queue_cmd(OP_DELETE,     10'd3,    32'h0);          // head
    queue_cmd(OP_DELETE,     10'd4,    32'h0);          // tail
    queue_cmd(OP_DELETE,     10'd5,    32'h0);          // middle
    queue_cmd(OP_READ,       10'd5,    32'h0);          // stale links of a dead node
    queue_cmd(OP_DELETE,     10'd5,    32'h0);          // dead node, links used as read
    queue_cmd(OP_INS_LEFT,   10'd0,    32'h1234_5678);  // anchor is the null slot
    queue_cmd(OP_INS_RIGHT,  10'd0,    32'h8765_4321);
    queue_cmd(OP_PUSH_FRONT, 10'd0,    32'h0000_0001);
    queue_cmd(OP_PUSH_BACK,  10'd0,    32'hFFFF_FFFE);
    queue_cmd(OP_READ,       10'd6,    32'h0);
    queue_cmd(OP_DELETE,     10'd1,    32'h0);
    queue_cmd(OP_READ,       10'd2,    32'h0);

    // Random: insert-heavy so the pool fills before the end and the rest of
    // the run exercises refused inserts, and deletes/reads up to slot 1023.
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      r = $urandom_range(0, 99);
      if      (r < 16) op = OP_PUSH_FRONT;
      else if (r < 32) op = OP_PUSH_BACK;
      else if (r < 55) op = OP_INS_LEFT;
      else if (r < 78) op = OP_INS_RIGHT;
      else if (r < 88) op = OP_DELETE;
      else if (r < 97) op = OP_READ;
      else if (r < 99) op = OP_NOP;
      else             op = OP_SPARE;
      // pushes and spare codes ignore the index, so any value goes there
      if (op == OP_DELETE || op == OP_INS_LEFT || op == OP_INS_RIGHT || op == OP_READ)
        idx = pick_target();
      else
        idx = IDX_W'($urandom);
      queue_cmd(op, idx, $urandom);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || staged || start || expected_beats.size() != 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("summary: %0d commands (%0d push front, %0d push back, %0d insert left,",
             accepted_cmds, op_seen[OP_PUSH_FRONT], op_seen[OP_PUSH_BACK],
             op_seen[OP_INS_LEFT]);
    $display("summary: %0d insert right, %0d delete, %0d read, %0d spare), %0d refused, %0d beats",
             op_seen[OP_INS_RIGHT], op_seen[OP_DELETE], op_seen[OP_READ],
             op_seen[OP_NOP] + op_seen[OP_SPARE], refused_inserts, checked_beats);
    if (fail_count == 0 && expected_beats.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/idll_pkg.sv
rtl/idll_ram.sv
rtl/idll_front.sv
rtl/idll_back.sv
rtl/indexed_doubly_linked_list.sv
verif/indexed_doubly_linked_list_test.sv
